// ----- sv/smdrt_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// slot map dirty range tracker. No dependencies.
package smdrt_pkg;

  localparam int MAX_OBJECTS_DEF     = 64;
  localparam int PLACEMENT_WIDTH_DEF = 64;
  localparam int ATTRIBUTE_WIDTH_DEF = 32;

  // A sync reports at most this many runs; the last one absorbs the rest.
  localparam int RESULT_LIMIT = 32;
  localparam int RUN_CNT_W    = $clog2(RESULT_LIMIT);

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SYNC     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic move;
    logic scan_step;
    logic flush;
  } smdrt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              rem_ok;
    logic              sync_quick;
    logic              scan_end;
  } smdrt_stat_t;

endpackage

// ----- sv/slot_map_dirty_range_tracker.sv -----
// Top level of the slot map dirty range tracker: controller plus datapath.
// Depends on smdrt_pkg, smdrt_ctrl and smdrt_datapath.
//
// A command word is taken when start is high and busy is low; busy stays
// high until the word's last result has been presented. Results appear on
// the out_ ports for exactly one cycle each, marked by out_valid, and
// out_last_result flags the final result of a word. The receiver cannot
// hold results off; the scanner holds back at most one closed run.
// Register, update, clear and unknown codes answer from the execute
// state; a valid remove adds a move state, because the moved entry is read
// from the dense store before it is written into the hole. A sync answers
// from the execute state when the table is empty or a full range is owed;
// otherwise it walks the dirty marks one dense index per cycle, emitting
// its runs along the way, and ends in a flush state.
// After reset the table is empty, no handles are issued, no marks are set
// and a full-range upload is owed to the first sync.
// The stores need no clearing pass, so a word may start right after reset.
module slot_map_dirty_range_tracker
  import smdrt_pkg::*;
#(
  parameter int MAX_OBJECTS     = MAX_OBJECTS_DEF,
  parameter int PLACEMENT_WIDTH = PLACEMENT_WIDTH_DEF,
  parameter int ATTRIBUTE_WIDTH = ATTRIBUTE_WIDTH_DEF,
  localparam int HW = $clog2(MAX_OBJECTS + 1),
  localparam int IW = $clog2(MAX_OBJECTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [HW-1:0]              in_handle,
  input  logic [PLACEMENT_WIDTH-1:0] in_placement_data,
  input  logic [ATTRIBUTE_WIDTH-1:0] in_attribute_data,
  output logic                       out_valid,
  output logic [HW-1:0]              out_new_handle,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IW-1:0]              out_range_start,
  output logic [HW-1:0]              out_range_count,
  output logic [HW-1:0]              out_live_count,
  output logic                       out_last_result
);

  smdrt_cmd_t  cmd;
  smdrt_stat_t stat;

  smdrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  smdrt_datapath #(
    .MAX_OBJECTS     (MAX_OBJECTS),
    .PLACEMENT_WIDTH (PLACEMENT_WIDTH),
    .ATTRIBUTE_WIDTH (ATTRIBUTE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_placement_data (in_placement_data),
    .in_attribute_data (in_attribute_data),
    .out_valid         (out_valid),
    .out_new_handle    (out_new_handle),
    .out_status        (out_status),
    .out_range_start   (out_range_start),
    .out_range_count   (out_range_count),
    .out_live_count    (out_live_count),
    .out_last_result   (out_last_result)
  );

endmodule

// ----- sv/smdrt_ctrl.sv -----
// Sequencing state machine for the slot map dirty range tracker.
// Depends on smdrt_pkg for the command and status types.
module smdrt_ctrl
  import smdrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  smdrt_stat_t stat,
  output smdrt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.func == FUNC_REMOVE && stat.rem_ok) begin
          state_nxt = S_MOVE;
        end else if (stat.func == FUNC_SYNC && !stat.sync_quick) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- sv/smdrt_datapath.sv -----
// Datapath of the slot map dirty range tracker: handle and dense stores,
// free stack, dirty marks, run scanner and result register. Uses smdrt_pkg.
module smdrt_datapath
  import smdrt_pkg::*;
#(
  parameter int MAX_OBJECTS     = MAX_OBJECTS_DEF,
  parameter int PLACEMENT_WIDTH = PLACEMENT_WIDTH_DEF,
  parameter int ATTRIBUTE_WIDTH = ATTRIBUTE_WIDTH_DEF,
  localparam int HW = $clog2(MAX_OBJECTS + 1),
  localparam int IW = $clog2(MAX_OBJECTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smdrt_cmd_t                 cmd,
  output smdrt_stat_t                stat,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [HW-1:0]              in_handle,
  input  logic [PLACEMENT_WIDTH-1:0] in_placement_data,
  input  logic [ATTRIBUTE_WIDTH-1:0] in_attribute_data,
  output logic                       out_valid,
  output logic [HW-1:0]              out_new_handle,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IW-1:0]              out_range_start,
  output logic [HW-1:0]              out_range_count,
  output logic [HW-1:0]              out_live_count,
  output logic                       out_last_result
);

  localparam logic [HW-1:0] MAX_H = HW'(MAX_OBJECTS);
  localparam logic [HW-1:0] ONE_H = HW'(1);

  // Captured word.
  logic [FUNC_W-1:0]          func_r;
  logic [HW-1:0]              handle_r;
  logic [PLACEMENT_WIDTH-1:0] place_r;
  logic [ATTRIBUTE_WIDTH-1:0] attr_r;

  // Control state.
  logic [MAX_OBJECTS-1:0] live_r, live_nxt;
  logic [MAX_OBJECTS-1:0] dirty_r, dirty_nxt;
  logic [HW-1:0]          fd_r, fd_nxt, hw_r, hw_nxt, lt_r, lt_nxt;
  logic                   pend_full_r, pend_full_nxt;

  // Stores.
  logic [HW-1:0]              fs_mem  [MAX_OBJECTS];
  logic [IW-1:0]              sp_mem  [MAX_OBJECTS];
  logic [HW-1:0]              own_mem [MAX_OBJECTS];
  logic [PLACEMENT_WIDTH-1:0] plc_mem [MAX_OBJECTS];
  logic [ATTRIBUTE_WIDTH-1:0] atr_mem [MAX_OBJECTS];
  logic [HW-1:0]              fs_q, own_q;
  logic [IW-1:0]              sp_q;
  logic [PLACEMENT_WIDTH-1:0] plc_q;
  logic [ATTRIBUTE_WIDTH-1:0] atr_q;

  // Scanner.
  logic [HW-1:0]        scan_i_r;
  logic [RUN_CNT_W-1:0] n_r;
  logic                 in_run_r, tail_r, pend_v_r;
  logic [IW-1:0]        run_start_r, last_d_r, pend_start_r;
  logic [HW-1:0]        pend_cnt_r;

  logic [HW-1:0] fd_m1, in_hm1, hm1, lt_m1, nh, own_m1, close_cnt;
  logic [IW-1:0] h_idx, lt_idx, last_idx, pos, scan_idx;
  logic          hok, rem_ok, reg_pop, reg_ok, reg_go, upd_go, mv_swap;
  logic          sync_quick, d, at_end, close, open;

  logic                emit, e_last;
  logic [HW-1:0]       e_nh, e_rc;
  logic [STATUS_W-1:0] e_st;
  logic [IW-1:0]       e_rs;

  function automatic logic [IW-1:0] hm1_nh();
    logic [HW-1:0] t;
    t = nh - ONE_H;
    return t[IW-1:0];
  endfunction

  assign fd_m1    = fd_r - ONE_H;
  assign in_hm1   = in_handle - ONE_H;
  assign hm1      = handle_r - ONE_H;
  assign lt_m1    = lt_r - ONE_H;
  assign h_idx    = hm1[IW-1:0];
  assign lt_idx   = lt_r[IW-1:0];
  assign last_idx = lt_m1[IW-1:0];
  assign pos      = sp_q;

  assign hok        = (handle_r != '0) && (handle_r <= hw_r) && live_r[h_idx];
  assign rem_ok     = hok && (lt_r != '0);
  assign reg_pop    = (fd_r != '0);
  assign reg_ok     = reg_pop || (hw_r != MAX_H);
  assign nh         = reg_pop ? fs_q : hw_r + ONE_H;
  assign own_m1     = own_q - ONE_H;
  assign sync_quick = (lt_r == '0) || pend_full_r;

  assign reg_go  = cmd.exec && (func_r == FUNC_REGISTER) && reg_ok;
  assign upd_go  = cmd.exec && (func_r == FUNC_UPDATE) && hok && (HW'(pos) < lt_r);
  assign mv_swap = cmd.move && (pos != last_idx);

  // One index of the dirty marks per scan cycle.
  assign scan_idx  = scan_i_r[IW-1:0];
  assign at_end    = (scan_i_r == lt_r);
  assign d         = dirty_r[scan_idx];
  assign close     = in_run_r && (at_end || (!tail_r && !d));
  assign open      = !at_end && !in_run_r && d;
  assign close_cnt = tail_r ? (HW'(last_d_r) - HW'(run_start_r) + ONE_H)
                            : (scan_i_r - HW'(run_start_r));

  assign stat.func       = func_r;
  assign stat.rem_ok     = rem_ok;
  assign stat.sync_quick = sync_quick;
  assign stat.scan_end   = at_end;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      handle_r <= in_handle;
      place_r  <= in_placement_data;
      attr_r   <= in_attribute_data;
      fs_q     <= fs_mem[fd_m1[IW-1:0]];
      sp_q     <= sp_mem[in_hm1[IW-1:0]];
    end
    if (cmd.exec) begin
      own_q <= own_mem[last_idx];
      plc_q <= plc_mem[last_idx];
      atr_q <= atr_mem[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (reg_go) begin
      sp_mem[hm1_nh()] <= lt_idx;
    end else if (mv_swap) begin
      sp_mem[own_m1[IW-1:0]] <= pos;
    end
    if (reg_go) begin
      own_mem[lt_idx] <= nh;
      plc_mem[lt_idx] <= place_r;
      atr_mem[lt_idx] <= attr_r;
    end else if (mv_swap) begin
      own_mem[pos] <= own_q;
      plc_mem[pos] <= plc_q;
      atr_mem[pos] <= atr_q;
    end else if (upd_go) begin
      plc_mem[pos] <= place_r;
    end
    if (cmd.move && (fd_r < MAX_H)) begin
      fs_mem[fd_r[IW-1:0]] <= handle_r;
    end
  end

  always_comb begin
    live_nxt      = live_r;
    dirty_nxt     = dirty_r;
    fd_nxt        = fd_r;
    hw_nxt        = hw_r;
    lt_nxt        = lt_r;
    pend_full_nxt = pend_full_r;
    if (reg_go) begin
      if (reg_pop) begin
        fd_nxt = fd_m1;
      end else begin
        hw_nxt = hw_r + ONE_H;
      end
      live_nxt[hm1_nh()] = 1'b1;
      dirty_nxt[lt_idx]  = 1'b1;
      lt_nxt             = lt_r + ONE_H;
    end
    if (upd_go) begin
      dirty_nxt[pos] = 1'b1;
    end
    if (cmd.move) begin
      if (mv_swap) begin
        dirty_nxt[pos] = 1'b1;
      end
      dirty_nxt[last_idx] = 1'b0;
      lt_nxt              = lt_m1;
      live_nxt[h_idx]     = 1'b0;
      if (fd_r < MAX_H) begin
        fd_nxt = fd_r + ONE_H;
      end
    end
    if ((cmd.exec && func_r == FUNC_SYNC && sync_quick) || cmd.flush) begin
      dirty_nxt     = '0;
      pend_full_nxt = 1'b0;
    end
    if (cmd.exec && func_r == FUNC_CLEAR) begin
      live_nxt      = '0;
      dirty_nxt     = '0;
      fd_nxt        = '0;
      hw_nxt        = '0;
      lt_nxt        = '0;
      pend_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      dirty_r     <= '0;
      fd_r        <= '0;
      hw_r        <= '0;
      lt_r        <= '0;
      pend_full_r <= 1'b1;
    end else begin
      live_r      <= live_nxt;
      dirty_r     <= dirty_nxt;
      fd_r        <= fd_nxt;
      hw_r        <= hw_nxt;
      lt_r        <= lt_nxt;
      pend_full_r <= pend_full_nxt;
    end
  end

  // A closed run is held back until the next run closes or the flush, so
  // that the final one can carry the last-word flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_i_r     <= '0;
      n_r          <= '0;
      in_run_r     <= 1'b0;
      tail_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      run_start_r  <= '0;
      last_d_r     <= '0;
      pend_start_r <= '0;
      pend_cnt_r   <= '0;
    end else if (cmd.exec) begin
      scan_i_r <= '0;
      n_r      <= '0;
      in_run_r <= 1'b0;
      tail_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (close) begin
        in_run_r     <= 1'b0;
        pend_v_r     <= 1'b1;
        pend_start_r <= run_start_r;
        pend_cnt_r   <= close_cnt;
      end
      if (open) begin
        in_run_r    <= 1'b1;
        run_start_r <= scan_idx;
        last_d_r    <= scan_idx;
        tail_r      <= (n_r == RUN_CNT_W'(RESULT_LIMIT - 1));
        if (n_r != RUN_CNT_W'(RESULT_LIMIT - 1)) begin
          n_r <= n_r + RUN_CNT_W'(1);
        end
      end
      if (tail_r && d && !at_end) begin
        last_d_r <= scan_idx;
      end
      if (!at_end) begin
        scan_i_r <= scan_i_r + ONE_H;
      end
    end
  end

  always_comb begin
    emit   = 1'b0;
    e_last = 1'b1;
    e_nh   = '0;
    e_st   = ST_OK;
    e_rs   = '0;
    e_rc   = '0;
    if (cmd.exec) begin
      case (func_r)
        FUNC_REGISTER: begin
          emit = 1'b1;
          e_nh = reg_ok ? nh : '0;
          e_st = reg_ok ? ST_OK : ST_FULL;
        end
        FUNC_REMOVE: begin
          emit = !rem_ok;
          e_st = ST_INVALID;
        end
        FUNC_UPDATE: begin
          emit = 1'b1;
          e_st = hok ? ST_OK : ST_INVALID;
        end
        FUNC_SYNC: begin
          emit = sync_quick;
          e_st = (lt_r == '0) ? ST_EMPTY : ST_OK;
          e_rc = (lt_r == '0) ? '0 : lt_r;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end else if (cmd.move) begin
      emit = 1'b1;
    end else if (cmd.scan_step) begin
      emit   = close && pend_v_r;
      e_last = 1'b0;
      e_rs   = pend_start_r;
      e_rc   = pend_cnt_r;
    end else if (cmd.flush) begin
      emit = 1'b1;
      e_st = pend_v_r ? ST_OK : ST_EMPTY;
      e_rs = pend_v_r ? pend_start_r : '0;
      e_rc = pend_v_r ? pend_cnt_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
    if (emit) begin
      out_new_handle  <= e_nh;
      out_status      <= e_st;
      out_range_start <= e_rs;
      out_range_count <= e_rc;
      out_last_result <= e_last;
    end
  end

  assign out_live_count = lt_r;

  // Every handle ever issued is either live or waiting on the free stack.
  a_handle_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fd_r} + {1'b0, lt_r}) == {1'b0, hw_r})
    else $error("free depth plus live count differs from high-water mark");

  a_flush_forgets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (dirty_r == '0) && !pend_full_r)
    else $error("dirty state survives the end of a sync");

  a_marks_below_live: assert property (@(posedge clk) disable iff (!rst_n)
    (lt_r != MAX_H) |-> (dirty_r[lt_idx] == 1'b0))
    else $error("dirty mark found at the first unused dense index");

endmodule

// ----- verif/slot_map_dirty_range_tracker_tb.sv -----
// Self-checking testbench for slot_map_dirty_range_tracker: a directed table,
// a fill sequence and random words, checked against an in-bench table model
// or a typed row's own answer. Depends on smdrt_pkg and the RTL of the block.
module slot_map_dirty_range_tracker_tb;
  import smdrt_pkg::*;

  localparam int SLOTS = MAX_OBJECTS_DEF;
  localparam int ITEMS = 470;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  typedef struct {
    logic [6:0]          nh;
    logic [STATUS_W-1:0] st;
    logic [5:0]          rs;
    logic [6:0]          rc;
    logic [6:0]          lc;
    logic                last;
  } answer_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [6:0]        handle;
    logic [63:0]       place;
    logic [31:0]       attr;
    bit                typed;
    answer_t           ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [6:0] in_handle = '0;
  logic [63:0] in_placement_data = '0;
  logic [31:0] in_attribute_data = '0;
  logic out_valid;
  logic [6:0] out_new_handle;
  logic [STATUS_W-1:0] out_status;
  logic [5:0] out_range_start;
  logic [6:0] out_range_count;
  logic [6:0] out_live_count;
  logic out_last_result;

  // Table model state.
  bit         m_live[SLOTS];
  logic [5:0] m_pos[SLOTS];
  logic [6:0] m_owner[SLOTS];
  logic [6:0] m_free[SLOTS];
  int         m_free_depth, m_high_water, m_live_total;
  bit         m_dirty[SLOTS];
  bit         m_full_pending;

  answer_t pending_answers[$];
  int mismatches = 0;
  int words_sent = 0;
  int burst_left = 1;

  slot_map_dirty_range_tracker i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_handle(in_handle),
    .in_placement_data(in_placement_data), .in_attribute_data(in_attribute_data),
    .out_valid(out_valid), .out_new_handle(out_new_handle), .out_status(out_status),
    .out_range_start(out_range_start), .out_range_count(out_range_count),
    .out_live_count(out_live_count), .out_last_result(out_last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void queue_answer(int nh, logic [STATUS_W-1:0] st, int rs, int rc);
    answer_t a;
    a.nh = nh[6:0];
    a.st = st;
    a.rs = rs[5:0];
    a.rc = rc[6:0];
    a.lc = m_live_total[6:0];
    a.last = 1'b0;
    pending_answers = {pending_answers, a};
  endfunction

  function automatic bool_ok(int h);
    return h != 0 && h <= m_high_water && h <= SLOTS && m_live[h-1];
  endfunction

  function automatic void forget_table();
    foreach (m_live[i]) begin
      m_live[i] = 0;
      m_dirty[i] = 0;
    end
    m_free_depth = 0;
    m_high_water = 0;
    m_live_total = 0;
    m_full_pending = 1;
  endfunction

  function automatic void report_dirty_runs();
    bit any = 0;
    int last_dirty = 0;
    int runs = 0;
    int i = 0;
    int first;
    foreach (m_dirty[k]) if (m_dirty[k]) begin
      any = 1;
      last_dirty = k;
    end
    if ((!any && !m_full_pending) || m_live_total == 0) begin
      queue_answer(0, ST_EMPTY, 0, 0);
    end else if (m_full_pending) begin
      queue_answer(0, ST_OK, 0, m_live_total);
    end else begin
      while (i < m_live_total) begin
        if (!m_dirty[i]) begin
          i++;
          continue;
        end
        first = i;
        // The final permitted run swallows every later dirty index.
        if (runs == RESULT_LIMIT - 1) begin
          queue_answer(0, ST_OK, first, last_dirty - first + 1);
          break;
        end
        while (i < m_live_total && m_dirty[i]) i++;
        queue_answer(0, ST_OK, first, i - first);
        runs++;
      end
    end
    foreach (m_dirty[k]) m_dirty[k] = 0;
    m_full_pending = 0;
  endfunction

  function automatic void predict_table(logic [FUNC_W-1:0] f, int h);
    int nh, p, last, mover;
    case (f)
      FUNC_REGISTER: begin
        if (m_free_depth > 0) begin
          m_free_depth--;
          nh = m_free[m_free_depth];
        end else if (m_high_water < SLOTS) begin
          m_high_water++;
          nh = m_high_water;
        end else begin
          nh = 0;
        end
        if (nh == 0) begin
          queue_answer(0, ST_FULL, 0, 0);
        end else begin
          p = m_live_total;
          m_live[nh-1] = 1;
          m_pos[nh-1] = p[5:0];
          m_owner[p] = nh[6:0];
          m_dirty[p] = 1;
          m_live_total++;
          queue_answer(nh, ST_OK, 0, 0);
        end
      end
      FUNC_REMOVE: begin
        if (!bool_ok(h) || m_live_total == 0) begin
          queue_answer(0, ST_INVALID, 0, 0);
        end else begin
          p = m_pos[h-1];
          last = m_live_total - 1;
          if (p != last) begin
            mover = m_owner[last];
            m_owner[p] = mover[6:0];
            m_pos[mover-1] = p[5:0];
            m_dirty[p] = 1;
          end
          m_dirty[last] = 0;
          m_live_total = last;
          m_live[h-1] = 0;
          m_free[m_free_depth] = h[6:0];
          m_free_depth++;
          queue_answer(0, ST_OK, 0, 0);
        end
      end
      FUNC_UPDATE: begin
        if (!bool_ok(h)) begin
          queue_answer(0, ST_INVALID, 0, 0);
        end else begin
          m_dirty[m_pos[h-1]] = 1;
          queue_answer(0, ST_OK, 0, 0);
        end
      end
      FUNC_SYNC: report_dirty_runs();
      FUNC_CLEAR: begin
        forget_table();
        queue_answer(0, ST_OK, 0, 0);
      end
      default: queue_answer(0, ST_OK, 0, 0);
    endcase
    pending_answers[pending_answers.size()-1].last = 1'b1;
  endfunction

  // Drives one word, waits for the handshake and records what it should cause.
  task automatic send_word(logic [FUNC_W-1:0] f, int h, logic [63:0] p, logic [31:0] a);
    start <= 1'b1;
    in_func <= f;
    in_handle <= h[6:0];
    in_placement_data <= p;
    in_attribute_data <= a;
    do @(posedge clk); while (busy);
    predict_table(f, h);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  function automatic int pick_handle();
    int h = $urandom_range(1, SLOTS);
    if ($urandom_range(0, 9) < 8 && m_live_total > 0)
      while (!m_live[h-1]) h = (h % SLOTS) + 1;
    else if ($urandom_range(0, 3) == 0)
      h = 0;
    return h;
  endfunction

  function automatic logic [63:0] rand_place();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", out_status);
      end else begin
        e = pending_answers.pop_front();
        if (out_new_handle !== e.nh || out_status !== e.st || out_range_start !== e.rs ||
            out_range_count !== e.rc || out_live_count !== e.lc ||
            out_last_result !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp nh=%0d st=%0d rs=%0d rc=%0d live=%0d last=%0d",
                     e.nh, e.st, e.rs, e.rc, e.lc, e.last);
            $display("          got nh=%0d st=%0d rs=%0d rc=%0d live=%0d last=%0d",
                     out_new_handle, out_status, out_range_start, out_range_count,
                     out_live_count, out_last_result);
          end
        end
      end
    end
  end

  function automatic row_t mk(logic [FUNC_W-1:0] f, int h, logic [63:0] p, logic [31:0] a,
                              bit typed, int nh, logic [STATUS_W-1:0] st, int rc, int lc);
    row_t r;
    r.func = f;
    r.handle = h[6:0];
    r.place = p;
    r.attr = a;
    r.typed = typed;
    r.ans = '{nh[6:0], st, 6'd0, rc[6:0], lc[6:0], 1'b1};
    return r;
  endfunction

  initial begin
    row_t directed[$];
    int f, r, guard;
    forget_table();
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 1, 0, ST_EMPTY, 0, 0)};
    directed = {directed, mk(FUNC_REMOVE, 0, '0, '0, 1, 0, ST_INVALID, 0, 0)};
    directed = {directed, mk(FUNC_UPDATE, 64, '1, '0, 1, 0, ST_INVALID, 0, 0)};
    directed = {directed, mk(FUNC_REGISTER, 0, '1, '1, 1, 1, ST_OK, 0, 1)};
    directed = {directed, mk(FUNC_REGISTER, 0, '0, '0, 1, 2, ST_OK, 0, 2)};
    directed = {directed, mk(FUNC_REGISTER, 64, '1, '0, 1, 3, ST_OK, 0, 3)};
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 1, 0, ST_OK, 3, 3)};
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 1, 0, ST_EMPTY, 0, 3)};
    directed = {directed, mk(FUNC_UPDATE, 2, 64'h0123_4567_89ab_cdef, '0, 0, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_REMOVE, 1, '0, '0, 0, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_REMOVE, 1, '0, '0, 1, 0, ST_INVALID, 0, 2)};
    directed = {directed, mk(FUNC_UPDATE, 9, '0, '0, 1, 0, ST_INVALID, 0, 2)};
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 0, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_REGISTER, 0, '0, '1, 1, 1, ST_OK, 0, 3)};
    directed = {directed, mk(FUNC_REMOVE, 1, '0, '0, 0, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 0, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_SPARE_LO, 5, '1, '1, 1, 0, ST_OK, 0, 2)};
    directed = {directed, mk(FUNC_SPARE_HI, 0, '0, '0, 1, 0, ST_OK, 0, 2)};
    directed = {directed, mk(FUNC_CLEAR, 0, '0, '0, 1, 0, ST_OK, 0, 0)};
    directed = {directed, mk(FUNC_SYNC, 0, '0, '0, 1, 0, ST_EMPTY, 0, 0)};
    directed = {directed, mk(FUNC_REMOVE, 64, '0, '0, 1, 0, ST_INVALID, 0, 0)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].func, directed[i].handle, directed[i].place, directed[i].attr);
      if (directed[i].typed) begin
        pending_answers[pending_answers.size()-1] = directed[i].ans;
      end
    end

    // Fill to capacity, overflow, then dirty every other dense index so that
    // the sync hits the run limit.
    send_word(FUNC_CLEAR, 0, '0, '0);
    repeat (SLOTS + 2) send_word(FUNC_REGISTER, 0, rand_place(), $urandom());
    send_word(FUNC_SYNC, 0, '0, '0);
    for (int h = 1; h <= SLOTS; h += 2) send_word(FUNC_UPDATE, h, rand_place(), $urandom());
    send_word(FUNC_SYNC, 0, '0, '0);
    send_word(FUNC_UPDATE, SLOTS, rand_place(), '0);
    send_word(FUNC_SYNC, 0, '0, '0);

    while (words_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 38) f = FUNC_REGISTER;
      else if (r < 63) f = FUNC_REMOVE;
      else if (r < 83) f = FUNC_UPDATE;
      else if (r < 95) f = FUNC_SYNC;
      else if (r < 97) f = FUNC_CLEAR;
      else f = $urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI);
      send_word(f[FUNC_W-1:0], pick_handle(), rand_place(), $urandom());
    end
    start <= 1'b0;

    guard = 0;
    while (pending_answers.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- slot_map_dirty_range_tracker.f -----
sv/smdrt_pkg.sv
sv/smdrt_ctrl.sv
sv/smdrt_datapath.sv
sv/slot_map_dirty_range_tracker.sv
verif/slot_map_dirty_range_tracker_tb.sv
